// ===== hw/rtl/rbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types, constants and helper functions for the ray against unit box
// slab intersection block.
// ----------------------------------------------------------------------------
package rbs_pkg;

    // Number format: signed fixed point, FRAC_BITS fraction bits.
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAG_BITS   = WORD_BITS + 1;
    localparam int SHIFT_BITS = WORD_BITS - FRAC_BITS;

    // Divider takes one setup stage plus one stage per quotient bit.
    localparam int DIV_LAT  = WORD_BITS + 1;
    localparam int LANE_LAT = DIV_LAT + 1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [MAG_BITS-1:0]         mag_t;
    typedef logic [2*WORD_BITS-1:0]      prod_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t FX_ONE   = {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // Face codes.
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;
    localparam logic [2:0] FACE_NONE  = 3'd6;

    localparam logic [2:0] FACE_PLUS  [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};
    localparam logic [2:0] FACE_MINUS [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};

    // Hit kinds.
    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_ENTER  = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;

    // Configuration register indexes.
    localparam logic REG_MIN_DISTANCE = 1'b0;
    localparam logic REG_FAR_LIMIT    = 1'b1;

    // What one axis lane reports for a ray.
    typedef struct packed {
        word_t t_in;
        word_t t_out;
        logic  in_plus;
        logic  skip;
        logic  miss;
    } lane_res_t;

    // Saturating add to the word range.
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    // Magnitude product to signed fixed point, truncated toward zero.
    function automatic word_t mul_finish(input prod_t p, input logic neg);
        prod_t sh;
        prod_t cap;
        prod_t mag;
        sh  = p >> FRAC_BITS;
        cap = prod_t'(WORD_MAX) + prod_t'(neg);
        mag = (sh > cap) ? cap : sh;
        return neg ? word_t'(-mag) : word_t'(mag);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rbs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_div
// Pipelined fixed point divider: one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rbs_div (
    input  wire logic          aclk,
    input  wire logic          adv,
    input  wire logic          nneg,
    input  wire rbs_pkg::mag_t nmag,
    input  wire rbs_pkg::word_t den,
    output rbs_pkg::word_t     quot
);

    localparam int W = rbs_pkg::WORD_BITS;

    logic [W-1:0] r_reg    [0:W];
    logic [W-1:0] q_reg    [0:W];
    logic [W-1:0] dl_reg   [0:W];
    logic [W-1:0] dmag_reg [0:W];
    logic         neg_reg  [0:W];
    logic         ovf_reg  [0:W];
    logic         zero_reg [0:W];

    logic                              dneg;
    logic [W-1:0]                      dmag;
    logic [W+rbs_pkg::SHIFT_BITS:0]    nx;
    logic [W+rbs_pkg::SHIFT_BITS:0]    dx;

    // Setup: divisor magnitude, overflow test and first partial remainder.
    always_comb begin
        dneg = den[W-1];
        dmag = dneg ? W'(-den) : W'(den);
        nx   = (W + rbs_pkg::SHIFT_BITS + 1)'(nmag);
        dx   = {1'b0, dmag, {rbs_pkg::SHIFT_BITS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg[0]    <= W'(nmag >> rbs_pkg::SHIFT_BITS);
            q_reg[0]    <= '0;
            dl_reg[0]   <= {nmag[rbs_pkg::SHIFT_BITS-1:0], {rbs_pkg::FRAC_BITS{1'b0}}};
            dmag_reg[0] <= dmag;
            neg_reg[0]  <= nneg ^ dneg;
            ovf_reg[0]  <= (nx >= dx);
            zero_reg[0] <= (dmag == '0) || (nmag == '0);
        end
    end

    // One restoring step per stage.
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;
        always_comb begin
            trial = {r_reg[k], dl_reg[k][W-1]};
            diff  = trial - {1'b0, dmag_reg[k]};
            ge    = !diff[W];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                r_reg[k+1]    <= ge ? diff[W-1:0] : trial[W-1:0];
                q_reg[k+1]    <= {q_reg[k][W-2:0], ge};
                dl_reg[k+1]   <= {dl_reg[k][W-2:0], 1'b0};
                dmag_reg[k+1] <= dmag_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    // Saturate and apply the sign.
    logic [W-1:0] cap;
    logic [W-1:0] mag;
    always_comb begin
        cap = W'(rbs_pkg::WORD_MAX) + W'(neg_reg[W]);
        if (zero_reg[W]) begin
            mag = '0;
        end else if (ovf_reg[W] || (q_reg[W] > cap)) begin
            mag = cap;
        end else begin
            mag = q_reg[W];
        end
        quot = neg_reg[W] ? rbs_pkg::word_t'(-mag) : rbs_pkg::word_t'(mag);
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rbs_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_lane
// One axis lane: distances to the minus and plus planes of one slab.
// ----------------------------------------------------------------------------
module rbs_lane (
    input  wire logic           aclk,
    input  wire logic           adv,
    input  wire rbs_pkg::word_t org,
    input  wire rbs_pkg::word_t dir,
    output rbs_pkg::lane_res_t  res
);

    localparam int W = rbs_pkg::WORD_BITS;
    localparam int L = rbs_pkg::DIV_LAT;

    logic signed [W+1:0] num_m;
    logic signed [W+1:0] num_p;
    logic                neg_m;
    logic                neg_p;
    rbs_pkg::mag_t       mag_m;
    rbs_pkg::mag_t       mag_p;
    rbs_pkg::word_t      q_m;
    rbs_pkg::word_t      q_p;

    // Numerators: plane coordinate minus origin, as sign and magnitude.
    always_comb begin
        num_m = -(W+2)'(rbs_pkg::FX_ONE) - (W+2)'(org);
        num_p =  (W+2)'(rbs_pkg::FX_ONE) - (W+2)'(org);
        neg_m = num_m[W+1];
        neg_p = num_p[W+1];
        mag_m = neg_m ? rbs_pkg::mag_t'(-num_m) : rbs_pkg::mag_t'(num_m);
        mag_p = neg_p ? rbs_pkg::mag_t'(-num_p) : rbs_pkg::mag_t'(num_p);
    end

    rbs_div u_div_m (.aclk(aclk), .adv(adv), .nneg(neg_m), .nmag(mag_m), .den(dir), .quot(q_m));
    rbs_div u_div_p (.aclk(aclk), .adv(adv), .nneg(neg_p), .nmag(mag_p), .den(dir), .quot(q_p));

    // Flags travel beside the divider.
    logic dneg_reg [0:L-1];
    logic skip_reg [0:L-1];
    logic miss_reg [0:L-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dneg_reg[0] <= dir[W-1];
            skip_reg[0] <= (dir == '0);
            miss_reg[0] <= (dir == '0) &&
                           ((org < -rbs_pkg::FX_ONE) || (org > rbs_pkg::FX_ONE));
            for (int k = 1; k < L; k++) begin
                dneg_reg[k] <= dneg_reg[k-1];
                skip_reg[k] <= skip_reg[k-1];
                miss_reg[k] <= miss_reg[k-1];
            end
        end
    end

    // Order entry and exit by direction sign.
    always_ff @(posedge aclk) begin
        if (adv) begin
            res.t_in    <= dneg_reg[L-1] ? q_p : q_m;
            res.t_out   <= dneg_reg[L-1] ? q_m : q_p;
            res.in_plus <= dneg_reg[L-1];
            res.skip    <= skip_reg[L-1];
            res.miss    <= miss_reg[L-1];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ray_box_slab_intersect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against the unit cube -1..+1, slab test in signed Q16.16.
// ----------------------------------------------------------------------------
// A ray is accepted every cycle while the result side keeps up. Three axis
// lanes each run two pipelined dividers (one quotient bit per stage); after
// the lanes, a merge register clips the interval, a product register forms
// direction times distance, and a result register forms the points. A miss
// gives no result. Normal mode gives one result per ray; CSG mode gives an
// enter and an exit result, handed out one after the other, and no new ray is
// accepted until the exit result is taken. The whole pipeline holds while a
// result waits on m_tready.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Ray requests
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
    input  wire logic [191:0] s_tdata,
    // mode
    input  wire logic [0:0]   s_tuser,
    // Hit results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_distance, point_x, point_y, point_z
    output logic [127:0]      m_tdata,
    // face [2:0], hit_kind [4:3]
    output logic [4:0]        m_tuser,
    output logic              m_tlast
);

    localparam int W = rbs_pkg::WORD_BITS;
    localparam int L = rbs_pkg::LANE_LAT;

    typedef rbs_pkg::word_t word_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] min_distance_reg;
    logic [30:0] far_limit_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_distance_reg <= 16'd1;
            far_limit_reg    <= 31'h7FFF_FFFF;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                rbs_pkg::REG_MIN_DISTANCE: min_distance_reg <= pwdata[15:0];
                rbs_pkg::REG_FAR_LIMIT:    far_limit_reg    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rbs_pkg::REG_MIN_DISTANCE: prdata = {16'd0, min_distance_reg};
            rbs_pkg::REG_FAR_LIMIT:    prdata = {1'b0, far_limit_reg};
            default:                   prdata = '0;
        endcase
    end

    // Limits clamped to the word range.
    word_t lim;
    word_t mind;
    always_comb begin
        lim  = (64'(far_limit_reg) > 64'(rbs_pkg::WORD_MAX)) ?
               rbs_pkg::WORD_MAX : word_t'(far_limit_reg);
        mind = (64'(min_distance_reg) > 64'(rbs_pkg::WORD_MAX)) ?
               rbs_pkg::WORD_MAX : word_t'(min_distance_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result bundle is stuck.
    // ------------------------------------------------------------------
    logic ob_valid_reg;
    logic ob_csg_reg;
    logic ob_phase_reg;
    logic adv;
    logic out_last;

    assign out_last = !ob_csg_reg || ob_phase_reg;
    assign adv      = !ob_valid_reg || (m_tready && out_last);
    assign s_tready = adv;

    // Unpack the request.
    word_t in_org [3];
    word_t in_dir [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_org[i] = s_tdata[i*W +: W];
            in_dir[i] = s_tdata[(3+i)*W +: W];
        end
    end

    // ------------------------------------------------------------------
    // Axis lanes
    // ------------------------------------------------------------------
    rbs_pkg::lane_res_t lane_res [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        rbs_lane u_lane (
            .aclk(aclk), .adv(adv),
            .org(in_org[i]), .dir(in_dir[i]),
            .res(lane_res[i])
        );
    end

    // Ray data and valid travel beside the lanes.
    logic  v_reg    [0:L-1];
    word_t org_reg  [0:L-1][3];
    word_t dir_reg  [0:L-1][3];
    logic  mode_reg [0:L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < L; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < L; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            org_reg[0]  <= in_org;
            dir_reg[0]  <= in_dir;
            mode_reg[0] <= s_tuser[0];
            for (int k = 1; k < L; k++) begin
                org_reg[k]  <= org_reg[k-1];
                dir_reg[k]  <= dir_reg[k-1];
                mode_reg[k] <= mode_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Merge: clip the interval over the three lanes.
    // ------------------------------------------------------------------
    word_t      near_h;
    word_t      far_h;
    logic [2:0] near_f;
    logic [2:0] far_f;
    logic       any_miss;
    logic       hit;
    word_t      sel_h;
    logic [2:0] sel_f;
    logic       csg;

    always_comb begin
        near_h   = -lim;
        far_h    = lim;
        near_f   = rbs_pkg::FACE_NONE;
        far_f    = rbs_pkg::FACE_NONE;
        any_miss = 1'b0;
        csg      = mode_reg[L-1];
        for (int i = 0; i < 3; i++) begin
            if (lane_res[i].miss) begin
                any_miss = 1'b1;
            end
            if (!lane_res[i].skip) begin
                if (lane_res[i].t_in > near_h) begin
                    near_h = lane_res[i].t_in;
                    near_f = lane_res[i].in_plus ? rbs_pkg::FACE_PLUS[i] :
                                                   rbs_pkg::FACE_MINUS[i];
                end
                if (lane_res[i].t_out < far_h) begin
                    far_h = lane_res[i].t_out;
                    far_f = lane_res[i].in_plus ? rbs_pkg::FACE_MINUS[i] :
                                                  rbs_pkg::FACE_PLUS[i];
                end
            end
        end
        hit = v_reg[L-1] && !any_miss && !(near_h > far_h) && !(far_h < mind);
        if (!csg && (near_h < mind)) begin
            sel_h = far_h;
            sel_f = far_f;
        end else begin
            sel_h = near_h;
            sel_f = near_f;
        end
    end

    logic       mg_valid_reg;
    logic       mg_csg_reg;
    word_t      mg_h_reg   [2];
    logic [2:0] mg_f_reg   [2];
    word_t      mg_org_reg [3];
    word_t      mg_dir_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mg_valid_reg <= 1'b0;
        end else if (adv) begin
            mg_valid_reg <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mg_csg_reg  <= csg;
            mg_h_reg[0] <= sel_h;
            mg_f_reg[0] <= sel_f;
            mg_h_reg[1] <= far_h;
            mg_f_reg[1] <= far_f;
            mg_org_reg  <= org_reg[L-1];
            mg_dir_reg  <= dir_reg[L-1];
        end
    end

    // ------------------------------------------------------------------
    // Products: direction times distance, magnitudes, for both hits.
    // ------------------------------------------------------------------
    logic             pr_valid_reg;
    logic             pr_csg_reg;
    word_t            pr_h_reg   [2];
    logic [2:0]       pr_f_reg   [2];
    word_t            pr_org_reg [3];
    rbs_pkg::prod_t   pr_mag_reg [2][3];
    logic             pr_neg_reg [2][3];

    logic [W-1:0] dmag [3];
    logic [W-1:0] hmag [2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i] = mg_dir_reg[i][W-1] ? W'(-mg_dir_reg[i]) : W'(mg_dir_reg[i]);
        end
        for (int j = 0; j < 2; j++) begin
            hmag[j] = mg_h_reg[j][W-1] ? W'(-mg_h_reg[j]) : W'(mg_h_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_valid_reg <= 1'b0;
        end else if (adv) begin
            pr_valid_reg <= mg_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_csg_reg <= mg_csg_reg;
            pr_h_reg   <= mg_h_reg;
            pr_f_reg   <= mg_f_reg;
            pr_org_reg <= mg_org_reg;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    pr_mag_reg[j][i] <= rbs_pkg::prod_t'(dmag[i]) * rbs_pkg::prod_t'(hmag[j]);
                    pr_neg_reg[j][i] <= mg_dir_reg[i][W-1] ^ mg_h_reg[j][W-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result bundle: points formed, then one or two results handed out.
    // ------------------------------------------------------------------
    word_t      ob_h_reg  [2];
    word_t      ob_pt_reg [2][3];
    logic [2:0] ob_f_reg  [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_valid_reg <= 1'b0;
            ob_phase_reg <= 1'b0;
        end else if (adv) begin
            ob_valid_reg <= pr_valid_reg;
            ob_phase_reg <= 1'b0;
        end else if (m_tready) begin
            ob_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ob_csg_reg <= pr_csg_reg;
            ob_h_reg   <= pr_h_reg;
            ob_f_reg   <= pr_f_reg;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    ob_pt_reg[j][i] <= rbs_pkg::sat_add(pr_org_reg[i],
                        rbs_pkg::mul_finish(pr_mag_reg[j][i], pr_neg_reg[j][i]));
                end
            end
        end
    end

    // Output mux.
    always_comb begin
        m_tvalid = ob_valid_reg;
        m_tlast  = out_last;
        m_tdata  = {ob_pt_reg[ob_phase_reg][2], ob_pt_reg[ob_phase_reg][1],
                    ob_pt_reg[ob_phase_reg][0], ob_h_reg[ob_phase_reg]};
        if (!ob_csg_reg) begin
            m_tuser = {rbs_pkg::KIND_NORMAL, ob_f_reg[0]};
        end else if (!ob_phase_reg) begin
            m_tuser = {rbs_pkg::KIND_ENTER, ob_f_reg[0]};
        end else begin
            m_tuser = {rbs_pkg::KIND_EXIT, ob_f_reg[1]};
        end
    end

endmodule
`default_nettype wire
